/* rtl/phfs_pkg.sv */
// Shared types and constants of the parallel handshake frame sender.
package phfs_pkg;

  // Channel store geometry
  localparam int STORE_DEPTH = 512;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  // Position counter width and its store bound
  localparam int POS_W = 10;
  localparam logic [POS_W-1:0] STORE_LIMIT = POS_W'(STORE_DEPTH);

  // Command codes
  localparam logic [1:0] CMD_STORE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_POLL  = 2'd2;

  // Port register select codes
  localparam logic PORT_DATA = 1'b0;
  localparam logic PORT_CTRL = 1'b1;

  // Control register values
  localparam logic [7:0] CTRL_INIT   = 8'h10;
  localparam logic [7:0] CTRL_SELECT = 8'h14;
  localparam logic [7:0] CTRL_STROBE = 8'h15;

  // Configuration register indexes and reset values
  localparam logic CFG_CHANNEL_COUNT = 1'b0;
  localparam logic CFG_TIMEOUT_POLLS = 1'b1;
  localparam logic [8:0] CHANNEL_COUNT_RST = 9'd511;
  localparam logic [7:0] TIMEOUT_POLLS_RST = 8'd100;

  // Result buffer sizing
  localparam int MAX_RESULTS = 4;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0] command;
    logic [8:0] channel_index;
    logic [7:0] channel_value;
    logic       ack_bit;
    logic       busy_bit;
  } item_t;

  typedef struct packed {
    logic       port_select;
    logic [7:0] port_value;
    logic       last_write;
    logic       timed_out;
  } result_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
  } store_rd_t;

endpackage

/* rtl/phfs_store.sv */
// Channel byte store with a zeroing sweep after reset and a registered read port.
module phfs_store (
  input  logic                         clk,
  input  logic                         rst,
  input  phfs_pkg::store_wr_t          wr,
  input  phfs_pkg::store_rd_t          rd,
  output logic [7:0]                   rd_data,
  output logic                         clearing
);
  import phfs_pkg::*;

  logic [7:0]          mem [STORE_DEPTH];
  logic [STORE_AW-1:0] clr_addr;

  // Sweep every entry to zero once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + STORE_AW'(1);
      if (clr_addr == STORE_AW'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write port: sweep has priority, no requests arrive while it runs
  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'd0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read port: hold the last fetched byte until the next fetch
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

/* rtl/parallel_handshake_frame_sender_unit.sv */
// Top level of the parallel handshake frame sender.
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  item (command, index, value, status)
//   result    out        result_valid/result_stall  result (one port write)
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// A request enters an input register and is decoded into zero to four port
// writes, which load a four-entry result buffer that drains one write per cycle
// while result_stall is low. A request with writes waits in the input register
// until the buffer is empty or its last entry leaves; stores and polls without
// writes never wait. After reset the 512-entry channel store is swept to zero,
// during which item_stall stays high; configuration writes are taken at once.
module parallel_handshake_frame_sender_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  phfs_pkg::item_t     item,
  output logic                result_valid,
  input  logic                result_stall,
  output phfs_pkg::result_t   result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [8:0]          cfg_data
);
  import phfs_pkg::*;

  typedef enum logic [5:0] {
    PH_IDLE         = 6'b000001,
    PH_HDR_BUSY_LOW = 6'b000010,
    PH_ACK_HIGH     = 6'b000100,
    PH_ACK_LOW      = 6'b001000,
    PH_BUSY_HIGH    = 6'b010000,
    PH_BUSY_LOW     = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    SEC_COUNT = 3'b001,
    SEC_START = 3'b010,
    SEC_CHAN  = 3'b100
  } section_t;

  function automatic result_t mk_result(logic sel, logic [7:0] val, logic last, logic tmo);
    result_t r;
    r.port_select = sel;
    r.port_value  = val;
    r.last_write  = last;
    r.timed_out   = tmo;
    return r;
  endfunction

  // Configuration
  logic [8:0] channel_count;
  logic [7:0] timeout_polls;

  // Frame state
  phase_t     wait_phase, wait_phase_next;
  section_t   frame_section, frame_section_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0] poll_counter, poll_counter_next;
  logic [7:0] pending_reg, pending_reg_next;
  logic       pend_mem, pend_mem_next;

  // Input stage and result buffer
  logic              s1_valid;
  item_t             s1_item;
  logic              s1_go;
  logic [RCNT_W-1:0] nres;
  result_t           res  [MAX_RESULTS];
  result_t           rbuf [MAX_RESULTS];
  logic [RCNT_W-1:0] rcnt;
  logic              out_fire;
  logic              buf_free;
  logic              load;

  // Store interface
  store_wr_t  st_wr;
  store_rd_t  st_rd;
  logic [7:0] st_rd_data;
  logic       clearing;

  // Decode helpers
  logic [7:0]       poll_inc;
  logic             met;
  logic             tmo;
  logic [7:0]       pending_byte;
  logic [POS_W-1:0] pos_cand;

  phfs_store u_store (
    .clk      (clk),
    .rst      (rst),
    .wr       (st_wr),
    .rd       (st_rd),
    .rd_data  (st_rd_data),
    .clearing (clearing)
  );

  assign pending_byte = pend_mem ? st_rd_data : pending_reg;
  assign poll_inc     = poll_counter + 8'd1;

  // Wait condition of the current phase
  always_comb begin
    unique case (wait_phase)
      PH_ACK_HIGH:  met = s1_item.ack_bit;
      PH_ACK_LOW:   met = !s1_item.ack_bit;
      PH_BUSY_HIGH: met = s1_item.busy_bit;
      default:      met = !s1_item.busy_bit;
    endcase
  end

  assign tmo = !met && (poll_inc == timeout_polls);

  // Decode the held request into writes and the next frame state; requests that
  // touch the store cause no writes, so they never wait on the result buffer
  always_comb begin
    wait_phase_next    = wait_phase;
    frame_section_next = frame_section;
    byte_position_next = byte_position;
    poll_counter_next  = poll_counter;
    pending_reg_next   = pending_reg;
    pend_mem_next      = pend_mem;
    nres               = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    st_wr.en   = 1'b0;
    st_wr.addr = s1_item.channel_index[STORE_AW-1:0];
    st_wr.data = s1_item.channel_value;
    st_rd.en   = 1'b0;
    pos_cand   = (frame_section == SEC_START) ? '0 : byte_position + POS_W'(1);
    st_rd.addr = pos_cand[STORE_AW-1:0];

    unique case (s1_item.command)
      CMD_STORE: begin
        st_wr.en = s1_valid && (POS_W'(s1_item.channel_index) < STORE_LIMIT);
      end
      CMD_START: begin
        if (wait_phase == PH_IDLE) begin
          res[0] = mk_result(PORT_CTRL, CTRL_INIT, 1'b0, 1'b0);
          res[1] = mk_result(PORT_CTRL, CTRL_SELECT, 1'b0, 1'b0);
          res[2] = mk_result(PORT_DATA, {7'd0, channel_count[8]}, 1'b0, 1'b0);
          res[3] = mk_result(PORT_CTRL, CTRL_STROBE, 1'b1, 1'b0);
          nres   = RCNT_W'(4);
          frame_section_next = SEC_COUNT;
          byte_position_next = '0;
          poll_counter_next  = '0;
          wait_phase_next    = PH_HDR_BUSY_LOW;
        end
      end
      CMD_POLL: begin
        if (wait_phase != PH_IDLE) begin
          if (!met && !tmo) begin
            poll_counter_next = poll_inc;
          end else begin
            poll_counter_next = '0;
            unique case (wait_phase)
              PH_HDR_BUSY_LOW: begin
                frame_section_next = SEC_COUNT;
                pending_reg_next   = channel_count[7:0];
                pend_mem_next      = 1'b0;
                wait_phase_next    = PH_ACK_HIGH;
              end
              PH_ACK_HIGH: begin
                res[0] = mk_result(PORT_DATA, pending_byte, 1'b0, tmo);
                res[1] = mk_result(PORT_CTRL, CTRL_SELECT, 1'b1, tmo);
                nres   = RCNT_W'(2);
                wait_phase_next = PH_ACK_LOW;
              end
              PH_ACK_LOW: begin
                wait_phase_next = PH_BUSY_HIGH;
              end
              PH_BUSY_HIGH: begin
                res[0] = mk_result(PORT_CTRL, CTRL_STROBE, 1'b1, tmo);
                nres   = RCNT_W'(1);
                wait_phase_next = PH_BUSY_LOW;
              end
              default: begin
                // Byte done: go to the start code, the next channel byte, or idle
                if (frame_section == SEC_COUNT) begin
                  frame_section_next = SEC_START;
                  pending_reg_next   = 8'd0;
                  pend_mem_next      = 1'b0;
                  wait_phase_next    = PH_ACK_HIGH;
                end else begin
                  frame_section_next = SEC_CHAN;
                  byte_position_next = pos_cand;
                  if (pos_cand >= POS_W'(channel_count)) begin
                    wait_phase_next = PH_IDLE;
                  end else if (pos_cand < STORE_LIMIT) begin
                    st_rd.en        = s1_valid;
                    pend_mem_next   = 1'b1;
                    wait_phase_next = PH_ACK_HIGH;
                  end else begin
                    pending_reg_next = 8'd0;
                    pend_mem_next    = 1'b0;
                    wait_phase_next  = PH_ACK_HIGH;
                  end
                end
              end
            endcase
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Handshake control
  assign out_fire     = result_valid && !result_stall;
  assign buf_free     = (rcnt == '0) || ((rcnt == RCNT_W'(1)) && out_fire);
  assign s1_go        = s1_valid && ((nres == '0) || buf_free);
  assign load         = s1_go && (nres != '0);
  assign item_stall   = clearing || (s1_valid && !s1_go);
  assign result_valid = (rcnt != '0);
  assign result       = rbuf[0];
  assign cfg_ready    = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_item <= item;
    end
  end

  // Commit frame state for each decoded request
  always_ff @(posedge clk) begin
    if (rst) begin
      wait_phase    <= PH_IDLE;
      frame_section <= SEC_COUNT;
      byte_position <= '0;
      poll_counter  <= '0;
      pending_reg   <= '0;
      pend_mem      <= 1'b0;
    end else if (s1_go) begin
      wait_phase    <= wait_phase_next;
      frame_section <= frame_section_next;
      byte_position <= byte_position_next;
      poll_counter  <= poll_counter_next;
      pending_reg   <= pending_reg_next;
      pend_mem      <= pend_mem_next;
    end
  end

  // Result buffer: load a fresh batch or advance one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt <= '0;
    end else if (load) begin
      rcnt <= nres;
    end else if (out_fire) begin
      rcnt <= rcnt - RCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        rbuf[i] <= res[i];
      end
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        rbuf[i] <= rbuf[i+1];
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      timeout_polls <= TIMEOUT_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNEL_COUNT: channel_count <= cfg_data;
        CFG_TIMEOUT_POLLS: timeout_polls <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the parallel handshake frame sender unit.
`timescale 1ns / 1ps

module tb_top;
  import phfs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 8;

  typedef enum logic [5:0] {
    WT_IDLE              = 6'b000001,
    WT_PREAMBLE_BUSY_LOW = 6'b000010,
    WT_ACK_HIGH          = 6'b000100,
    WT_ACK_LOW           = 6'b001000,
    WT_BUSY_HIGH         = 6'b010000,
    WT_BUSY_LOW          = 6'b100000
  } hs_wait_t;

  typedef enum logic [2:0] {
    PART_COUNT      = 3'b001,
    PART_START_CODE = 3'b010,
    PART_CHANNELS   = 3'b100
  } frame_part_t;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_stall;
  item_t      item         = '0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  result_t    result;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic       cfg_index    = 1'b0;
  logic [8:0] cfg_data     = 9'd0;

  // Shadow of the sender: channel store, handshake wait and frame position
  logic [7:0]       shadow_store [STORE_DEPTH];
  hs_wait_t         hs_state   = WT_IDLE;
  frame_part_t      part       = PART_COUNT;
  logic [POS_W-1:0] slot_pos   = '0;
  logic [7:0]       poll_run   = 8'd0;
  logic [7:0]       held_byte  = 8'd0;
  logic [8:0]       cur_count  = CHANNEL_COUNT_RST;
  logic [7:0]       cur_limit  = TIMEOUT_POLLS_RST;
  result_t          port_writes [$];

  int send_pct       = 0;
  int recv_pct       = 0;
  bit side_on        = 1'b0;
  int requests_sent  = 0;
  int requests_taken = 0;
  int frames_started = 0;
  int writes_checked = 0;
  int forced_writes  = 0;
  int errors         = 0;
  int cycle_count    = 0;

  parallel_handshake_frame_sender_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Bound the run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Stall the result side at the rate of the current phase
  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < recv_pct);
  end

  function automatic void expect_write(logic sel, logic [7:0] val, logic last, logic forced);
    result_t w;
    w.port_select = sel;
    w.port_value  = val;
    w.last_write  = last;
    w.timed_out   = forced;
    port_writes.push_back(w);
  endfunction

  function automatic void begin_wait(hs_wait_t w);
    hs_state = w;
    poll_run = 8'd0;
  endfunction

  // Advance the shadow by one request and queue the port writes it causes
  function automatic void predict_port_writes(item_t it);
    logic met;
    logic forced;
    met = 1'b0;
    case (it.command)
      CMD_STORE: begin
        if (POS_W'(it.channel_index) < STORE_LIMIT)
          shadow_store[it.channel_index] = it.channel_value;
      end
      CMD_START: begin
        if (hs_state == WT_IDLE) begin
          expect_write(PORT_CTRL, CTRL_INIT, 1'b0, 1'b0);
          expect_write(PORT_CTRL, CTRL_SELECT, 1'b0, 1'b0);
          expect_write(PORT_DATA, (cur_count > 9'd255) ? 8'd1 : 8'd0, 1'b0, 1'b0);
          expect_write(PORT_CTRL, CTRL_STROBE, 1'b1, 1'b0);
          part = PART_COUNT;
          slot_pos = '0;
          begin_wait(WT_PREAMBLE_BUSY_LOW);
          frames_started++;
        end
      end
      CMD_POLL: begin
        if (hs_state != WT_IDLE) begin
          case (hs_state)
            WT_ACK_HIGH:  met = it.ack_bit;
            WT_ACK_LOW:   met = !it.ack_bit;
            WT_BUSY_HIGH: met = it.busy_bit;
            default:      met = !it.busy_bit;
          endcase
          // the counter wraps, so a limit of zero allows 256 polls
          poll_run = poll_run + 8'd1;
          forced = !met && (poll_run == cur_limit);
          if (met || forced) begin
            case (hs_state)
              WT_PREAMBLE_BUSY_LOW: begin
                part = PART_COUNT;
                held_byte = cur_count[7:0];
                begin_wait(WT_ACK_HIGH);
              end
              WT_ACK_HIGH: begin
                expect_write(PORT_DATA, held_byte, 1'b0, forced);
                expect_write(PORT_CTRL, CTRL_SELECT, 1'b1, forced);
                begin_wait(WT_ACK_LOW);
              end
              WT_ACK_LOW: begin_wait(WT_BUSY_HIGH);
              WT_BUSY_HIGH: begin
                expect_write(PORT_CTRL, CTRL_STROBE, 1'b1, forced);
                begin_wait(WT_BUSY_LOW);
              end
              default: begin
                // move on to the start code, the next channel byte, or idle
                if (part == PART_COUNT) begin
                  part = PART_START_CODE;
                  held_byte = 8'd0;
                  begin_wait(WT_ACK_HIGH);
                end else begin
                  if (part == PART_START_CODE) begin
                    part = PART_CHANNELS;
                    slot_pos = '0;
                  end else begin
                    slot_pos = slot_pos + POS_W'(1);
                  end
                  if (slot_pos >= POS_W'(cur_count)) begin
                    begin_wait(WT_IDLE);
                  end else begin
                    held_byte = (slot_pos < STORE_LIMIT) ?
                                shadow_store[slot_pos[STORE_AW-1:0]] : 8'd0;
                    begin_wait(WT_ACK_HIGH);
                  end
                end
              end
            endcase
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Track config writes, predict on each request, check each port write
  always @(posedge clk) begin : scoreboard
    result_t want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_CHANNEL_COUNT) cur_count = cfg_data;
        else cur_limit = cfg_data[7:0];
      end
      if (item_valid && !item_stall) begin
        requests_taken++;
        predict_port_writes(item);
      end
      if (result_valid && !result_stall) begin
        if (port_writes.size() == 0) begin
          $display("%0t: unexpected port write, expected none, actual %h", $time, result);
          errors++;
        end else begin
          want = port_writes.pop_front();
          writes_checked++;
          if (want.timed_out) forced_writes++;
          if (result.port_select !== want.port_select) begin
            $display("%0t: port_select expected %b actual %b", $time,
                     want.port_select, result.port_select);
            errors++;
          end
          if (result.port_value !== want.port_value) begin
            $display("%0t: port_value expected %h actual %h", $time,
                     want.port_value, result.port_value);
            errors++;
          end
          if (result.last_write !== want.last_write) begin
            $display("%0t: last_write expected %b actual %b", $time,
                     want.last_write, result.last_write);
            errors++;
          end
          if (result.timed_out !== want.timed_out) begin
            $display("%0t: timed_out expected %b actual %b", $time,
                     want.timed_out, result.timed_out);
            errors++;
          end
        end
      end
    end
  end

  function automatic item_t item_of(logic [1:0] cmd, logic [8:0] idx, logic [7:0] val,
                                    logic ack, logic busy);
    item_t it;
    it.command       = cmd;
    it.channel_index = idx;
    it.channel_value = val;
    it.ack_bit       = ack;
    it.busy_bit      = busy;
    return it;
  endfunction

  // Offer one request, idling first at the phase rate; hold until taken
  task automatic send_item(item_t it);
    logic [31:0] r;
    if ($urandom_range(99) < send_pct) begin
      r = $urandom;
      item_valid <= 1'b0;
      item <= r[$bits(item_t)-1:0];
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (it.command != CMD_UNUSED) requests_sent++;
  endtask

  // Drop valid and wait until every expected write is out and the block is quiet
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (port_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [8:0] count, logic [7:0] limit);
    logic [31:0] r;
    r = $urandom;
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= count;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    // the top data bit is don't-care for the poll limit
    cfg_index <= CFG_TIMEOUT_POLLS;
    cfg_data  <= {r[0], limit};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(idle_mode_t m);
    case (m)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 68; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 68; end
      default:   begin send_pct = 24; recv_pct = 24; end
    endcase
  endtask

  // Mix stores, stray starts and unused commands into a frame
  task automatic side_request();
    logic [31:0] r;
    int pick;
    r = $urandom;
    pick = $urandom_range(99);
    if (pick < 15)
      send_item(item_of(CMD_STORE, (r[31:30] != 2'd0) ? {5'd0, r[3:0]} : r[8:0],
                        r[16:9], r[17], r[18]));
    else if (pick < 18)
      send_item(item_of(CMD_START, r[8:0], r[16:9], r[17], r[18]));
    else if (pick < 20)
      send_item(item_of(CMD_UNUSED, r[8:0], r[16:9], r[17], r[18]));
  endtask

  // Poll one wait: misses that do not meet it, then optionally one that does
  task automatic run_wait(hs_wait_t w, int misses, logic close);
    logic [31:0] r;
    logic lvl;
    for (int i = 0; i < misses + int'(close); i++) begin
      if (side_on) side_request();
      r = $urandom;
      lvl = ((i == misses) == (w == WT_ACK_HIGH || w == WT_BUSY_HIGH));
      if (w == WT_ACK_HIGH || w == WT_ACK_LOW)
        send_item(item_of(CMD_POLL, r[8:0], r[16:9], lvl, r[20]));
      else
        send_item(item_of(CMD_POLL, r[8:0], r[16:9], r[20], lvl));
    end
  endtask

  function automatic int miss_count(int max_miss);
    return ($urandom_range(2) == 0) ? int'($urandom_range(max_miss)) : 0;
  endfunction

  // Start a frame and walk the preamble wait plus four waits per byte
  task automatic run_frame(int slots, int max_miss);
    logic [31:0] r;
    r = $urandom;
    send_item(item_of(CMD_START, r[8:0], r[16:9], r[17], r[18]));
    run_wait(WT_PREAMBLE_BUSY_LOW, miss_count(max_miss), 1'b1);
    repeat (slots) begin
      run_wait(WT_ACK_HIGH, miss_count(max_miss), 1'b1);
      run_wait(WT_ACK_LOW, miss_count(max_miss), 1'b1);
      run_wait(WT_BUSY_HIGH, miss_count(max_miss), 1'b1);
      run_wait(WT_BUSY_LOW, miss_count(max_miss), 1'b1);
    end
  endtask

  // Mostly well-formed frames with random content, the rest raw noise
  task automatic run_traffic(logic [8:0] count, logic [7:0] limit, idle_mode_t m,
                             int n, int max_miss);
    logic [31:0] r;
    int stop;
    settle();
    write_config(count, limit);
    set_idling(m);
    side_on = 1'b1;
    stop = requests_sent + n;
    while (requests_sent < stop) begin
      if ($urandom_range(4) != 0) begin
        run_frame((count <= 9'd2) ? int'(count) + 2 : 2, max_miss);
      end else begin
        repeat ($urandom_range(6, 1)) begin
          r = $urandom;
          send_item(r[$bits(item_t)-1:0]);
        end
      end
    end
  endtask

  task automatic test_store_and_ignored();
    set_idling(IDLE_NONE);
    send_item(item_of(CMD_STORE, 9'd0, 8'hFF, 1'b0, 1'b0));
    send_item(item_of(CMD_STORE, 9'd511, 8'hA5, 1'b1, 1'b1));
    send_item(item_of(CMD_STORE, 9'd1, 8'h5A, 1'b0, 1'b1));
    send_item(item_of(CMD_STORE, 9'd2, 8'h00, 1'b1, 1'b0));
    // poll while idle and the unused command cause nothing
    send_item(item_of(CMD_POLL, 9'd511, 8'hFF, 1'b1, 1'b1));
    send_item(item_of(CMD_UNUSED, 9'd511, 8'hFF, 1'b1, 1'b1));
  endtask

  // Frame at reset settings, shortened by a count change partway through
  task automatic test_reset_config_frame();
    send_item(item_of(CMD_START, 9'd0, 8'd0, 1'b0, 1'b0));
    send_item(item_of(CMD_START, 9'd3, 8'd7, 1'b1, 1'b1));
    run_wait(WT_PREAMBLE_BUSY_LOW, 1, 1'b1);
    run_wait(WT_ACK_HIGH, 0, 1'b1);
    run_wait(WT_ACK_LOW, 0, 1'b1);
    run_wait(WT_BUSY_HIGH, 0, 1'b1);
    settle();
    write_config(9'd2, 8'd100);
    run_wait(WT_BUSY_LOW, 0, 1'b1);
    repeat (3) begin
      run_wait(WT_ACK_HIGH, 0, 1'b1);
      run_wait(WT_ACK_LOW, 0, 1'b1);
      run_wait(WT_BUSY_HIGH, 0, 1'b1);
      run_wait(WT_BUSY_LOW, 0, 1'b1);
    end
  endtask

  task automatic test_short_frames();
    run_traffic(9'd2, 8'd100, IDLE_NONE, 20, 2);
  endtask

  task automatic test_empty_frames();
    run_traffic(9'd0, 8'd1, IDLE_SEND, 12, 2);
  endtask

  task automatic test_wide_count();
    run_traffic(9'd256, 8'd3, IDLE_BOTH, 12, 3);
  endtask

  task automatic test_long_waits();
    run_traffic(9'd1, 8'd255, IDLE_RECV, 20, 6);
  endtask

  task automatic test_tight_timeouts();
    run_traffic(9'd2, 8'd2, IDLE_BOTH, 20, 3);
  endtask

  task automatic test_mixed_settings();
    run_traffic(9'($urandom_range(2, 1)), 8'($urandom_range(8, 1)), IDLE_NONE, 20, 4);
  endtask

  // A zero poll limit means 256 polls: 255 misses pass, the 256th forces
  task automatic test_timeout_wrap();
    logic [31:0] r;
    side_on = 1'b0;
    settle();
    write_config(9'd0, 8'd1);
    // drain any frame still in progress, one poll at a time
    while (hs_state != WT_IDLE) begin
      r = $urandom;
      send_item(item_of(CMD_POLL, r[8:0], r[16:9], r[17], r[18]));
      settle();
    end
    write_config(9'd0, 8'd0);
    set_idling(IDLE_BOTH);
    r = $urandom;
    send_item(item_of(CMD_START, r[8:0], r[16:9], r[17], r[18]));
    run_wait(WT_PREAMBLE_BUSY_LOW, 0, 1'b1);
    run_wait(WT_ACK_HIGH, 256, 1'b0);
  endtask

  initial begin
    foreach (shadow_store[i]) shadow_store[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_store_and_ignored();
    test_reset_config_frame();
    test_short_frames();
    test_empty_frames();
    test_wide_count();
    test_long_waits();
    test_tight_timeouts();
    test_mixed_settings();
    test_timeout_wrap();

    settle();
    $display("Sent %0d requests (%0d taken), started %0d frames.",
             requests_sent, requests_taken, frames_started);
    $display("Checked %0d port writes, %0d of them after a forced timeout; %0d errors.",
             writes_checked, forced_writes, errors);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/phfs_pkg.sv
rtl/phfs_store.sv
rtl/parallel_handshake_frame_sender_unit.sv
bench/tb_top.sv
